/* hw/rtl/sbc_pkg.sv */
// ----------------------------------------------------------------------------
// sbc_pkg
// Types and constants shared by the sprite blitter pipeline stages.
// ----------------------------------------------------------------------------
package sbc_pkg;

  // Stream word widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned InDataW  = 168;
  localparam int unsigned OutDataW = 104;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;

  typedef enum logic [CfgIdxW-1:0] {
    RegDestWidth  = 2'd0,
    RegDestHeight = 2'd1,
    RegDestPitch  = 2'd2
  } cfg_reg_e;

  localparam logic [12:0] DestWidthRst  = 13'd640;
  localparam logic [12:0] DestHeightRst = 13'd480;
  localparam logic [14:0] DestPitchRst  = 15'd2560;

  // Sprite size limit; counters are sized to hold one less than this
  localparam logic [10:0] MaxSpriteDim = 11'd1024;
  localparam int unsigned CountW       = 10;

  // Width percent: saturate, then divide by 100 via reciprocal multiply.
  // floor(x * PctRecip / 2^PctShift) == floor(x / 100) for x below 2^17.
  localparam logic [6:0]  PctMax   = 7'd100;
  localparam logic [17:0] PctRecip = 18'd167773;
  localparam int unsigned PctShift = 24;

  localparam logic [31:0] ColorKey = 32'hffff_ffff;

  typedef enum logic {
    KindCommand = 1'b0,
    KindPixel   = 1'b1
  } item_kind_e;

  typedef enum logic [1:0] {
    ModeKey    = 2'd0,
    ModeOpaque = 2'd1,
    ModeShadow = 2'd2,
    ModeTint   = 2'd3
  } blend_mode_e;

  // Input register contents
  typedef struct packed {
    item_kind_e  kind;
    logic [10:0] sprite_w;
    logic [10:0] sprite_h;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] draw_x;
    logic [15:0] draw_y;
    blend_mode_e mode;
    logic [6:0]  pct;
    logic [31:0] src;
    logic [31:0] dst;
  } item_t;

  // After saturation, percent product and anchor subtraction
  typedef struct packed {
    item_kind_e  kind;
    blend_mode_e mode;
    logic [10:0] sw;
    logic [10:0] sh;
    logic [16:0] prod;
    logic [16:0] sx;
    logic [16:0] sy;
    logic [31:0] src;
    logic [31:0] dst;
  } prep_t;

  // After divide and row-offset products; ready for clipping
  typedef struct packed {
    item_kind_e  kind;
    blend_mode_e mode;
    logic [10:0] w;
    logic [10:0] sh;
    logic [10:0] sw;
    logic [16:0] sx;
    logic [16:0] sy;
    logic [19:0] src_row;
    logic [25:0] dst_row;
    logic [31:0] src;
    logic [31:0] dst;
  } geom_t;

  // Result register contents
  typedef struct packed {
    item_kind_e  kind;
    logic [25:0] addr;
    logic [19:0] soff;
    logic [10:0] rect_w;
    logic [10:0] rect_h;
    logic        empty;
    logic [31:0] pixel;
    logic        we;
    logic        last;
  } result_t;

endpackage

/* hw/rtl/sbc_prep.sv */
// ----------------------------------------------------------------------------
// sbc_prep
// Two command pre-processing stages: saturation and percent product, then
// divide by 100 and the start-row products. Pixel payload rides along.
// ----------------------------------------------------------------------------
module sbc_prep (
  input  logic            clk_i,
  input  sbc_pkg::item_t  item_i,
  input  logic            ld2_i,
  input  logic            ld3_i,
  input  logic [14:0]     dest_pitch_i,
  output sbc_pkg::geom_t  geom_o
);

  sbc_pkg::prep_t prep_d, prep_q;
  sbc_pkg::geom_t geom_d, geom_q;

  // Stage 2: saturate sizes and percent, form product and screen origin
  always_comb begin
    logic [6:0] pct;
    prep_d      = '0;
    prep_d.kind = item_i.kind;
    prep_d.mode = item_i.mode;
    prep_d.sw   = (item_i.sprite_w > sbc_pkg::MaxSpriteDim) ? sbc_pkg::MaxSpriteDim
                                                            : item_i.sprite_w;
    prep_d.sh   = (item_i.sprite_h > sbc_pkg::MaxSpriteDim) ? sbc_pkg::MaxSpriteDim
                                                            : item_i.sprite_h;
    pct         = (item_i.pct > sbc_pkg::PctMax) ? sbc_pkg::PctMax : item_i.pct;
    prep_d.prod = 17'(prep_d.sw * pct);
    prep_d.sx   = {item_i.draw_x[15], item_i.draw_x} - {item_i.center_x[15], item_i.center_x};
    prep_d.sy   = {item_i.draw_y[15], item_i.draw_y} - {item_i.center_y[15], item_i.center_y};
    prep_d.src  = item_i.src;
    prep_d.dst  = item_i.dst;
  end

  always_ff @(posedge clk_i) begin
    if (ld2_i) begin
      prep_q <= prep_d;
    end
  end

  // Stage 3: divide by 100, skipped-row offset and screen row offset
  always_comb begin
    logic [34:0] quot;
    logic [15:0] sky;
    logic [15:0] syc;
    logic [26:0] srow;
    logic [30:0] drow;
    quot = 35'(prep_q.prod * sbc_pkg::PctRecip);
    sky  = prep_q.sy[16] ? 16'(17'd0 - prep_q.sy) : 16'd0;
    syc  = prep_q.sy[16] ? 16'd0 : prep_q.sy[15:0];
    srow = 27'(sky * prep_q.sw);
    drow = 31'(syc * dest_pitch_i);

    geom_d         = '0;
    geom_d.kind    = prep_q.kind;
    geom_d.mode    = prep_q.mode;
    geom_d.w       = (prep_q.mode == sbc_pkg::ModeKey || prep_q.mode == sbc_pkg::ModeOpaque)
                     ? quot[sbc_pkg::PctShift +: 11] : prep_q.sw;
    geom_d.sh      = prep_q.sh;
    geom_d.sw      = prep_q.sw;
    geom_d.sx      = prep_q.sx;
    geom_d.sy      = prep_q.sy;
    geom_d.src_row = srow[19:0];
    geom_d.dst_row = drow[25:0];
    geom_d.src     = prep_q.src;
    geom_d.dst     = prep_q.dst;
  end

  always_ff @(posedge clk_i) begin
    if (ld3_i) begin
      geom_q <= geom_d;
    end
  end

  assign geom_o = geom_q;

endmodule

/* hw/rtl/sbc_blend.sv */
// ----------------------------------------------------------------------------
// sbc_blend
// Per-pixel compose: colour key, opaque, shadow halving and red tint.
// ----------------------------------------------------------------------------
module sbc_blend (
  input  sbc_pkg::blend_mode_e mode_i,
  input  logic [31:0]          src_i,
  input  logic [31:0]          dst_i,
  output logic [31:0]          pixel_o,
  output logic                 we_o
);

  always_comb begin
    logic [31:0] shade;
    logic [31:0] tint;
    shade = {dst_i[31:24],
             8'({1'b0, src_i[23:17]} + {1'b0, dst_i[23:17]}),
             8'({1'b0, src_i[15:9]}  + {1'b0, dst_i[15:9]}),
             8'({1'b0, src_i[7:1]}   + {1'b0, dst_i[7:1]})};
    tint  = {dst_i[31:24], src_i[23:16], 1'b0, src_i[15:9], 1'b0, src_i[7:1]};
    case (mode_i)
      sbc_pkg::ModeKey: begin
        we_o    = (src_i != sbc_pkg::ColorKey);
        pixel_o = we_o ? src_i : dst_i;
      end
      sbc_pkg::ModeOpaque: begin
        we_o    = 1'b1;
        pixel_o = src_i;
      end
      sbc_pkg::ModeShadow: begin
        // darken only where the sprite is fully zero
        we_o    = (src_i == '0);
        pixel_o = we_o ? shade : dst_i;
      end
      sbc_pkg::ModeTint: begin
        we_o    = (src_i != sbc_pkg::ColorKey);
        pixel_o = we_o ? tint : dst_i;
      end
      default: begin
        we_o    = 1'b0;
        pixel_o = dst_i;
      end
    endcase
  end

endmodule

/* hw/rtl/sbc_draw.sv */
// ----------------------------------------------------------------------------
// sbc_draw
// Clip stage, draw state and result register. Commands set up the
// rectangle; pixels walk it in raster order.
// ----------------------------------------------------------------------------
module sbc_draw (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbc_pkg::geom_t    geom_i,
  input  logic              step_i,
  input  logic              ld_i,
  input  logic [12:0]       dest_width_i,
  input  logic [12:0]       dest_height_i,
  input  logic [14:0]       dest_pitch_i,
  output logic              out_valid_o,
  output sbc_pkg::result_t  result_o
);

  localparam int unsigned CW = sbc_pkg::CountW;

  logic                 active_q, active_d;
  sbc_pkg::blend_mode_e mode_q, mode_d;
  logic [10:0]          clip_w_q, clip_w_d;
  logic [10:0]          clip_h_q, clip_h_d;
  logic [CW-1:0]        col_q, col_d;
  logic [CW-1:0]        row_q, row_d;
  logic [19:0]          src_base_q, src_base_d;
  logic [25:0]          dst_base_q, dst_base_d;
  logic [10:0]          stride_q, stride_d;
  logic                 out_valid_q, out_valid_d;
  sbc_pkg::result_t     res_q, res_d;

  // Clipping
  logic signed [19:0] sx, sy, w0, h0, dw, dh;
  logic signed [19:0] w1, w2, h1, h2, syc;
  logic [19:0]        skx;
  logic [25:0]        sxc4;
  logic               empty;
  logic [19:0]        cmd_soff;
  logic [25:0]        cmd_addr;

  always_comb begin
    sx   = 20'(signed'(geom_i.sx));
    sy   = 20'(signed'(geom_i.sy));
    w0   = signed'({9'd0, geom_i.w});
    h0   = signed'({9'd0, geom_i.sh});
    dw   = signed'({7'd0, dest_width_i});
    dh   = signed'({7'd0, dest_height_i});
    w1   = (dw < sx + w0) ? dw - sx : w0;
    w2   = sx[19] ? w1 + sx : w1;
    h1   = sy[19] ? h0 + sy : h0;
    syc  = sy[19] ? 20'sd0 : sy;
    h2   = (dh < syc + h1) ? dh - syc : h1;
    skx  = sx[19] ? 20'(-sx) : 20'd0;
    sxc4 = sx[19] ? 26'd0 : {8'd0, sx[15:0], 2'b00};
    empty    = (w2 <= 20'sd0) || (h2 <= 20'sd0);
    cmd_soff = geom_i.src_row + skx;
    cmd_addr = geom_i.dst_row + sxc4;
  end

  // Pixel address and source index
  logic [24:0]   row_pitch;
  logic [20:0]   row_stride;
  logic [25:0]   pix_addr;
  logic [19:0]   pix_soff;
  logic          col_end, last;
  logic [31:0]   blend_pixel;
  logic          blend_we;

  assign row_pitch  = 25'(row_q * dest_pitch_i);
  assign row_stride = 21'(row_q * stride_q);
  assign pix_addr   = dst_base_q + {14'd0, col_q, 2'b00} + {1'b0, row_pitch};
  assign pix_soff   = src_base_q + row_stride[19:0] + {10'd0, col_q};
  assign col_end    = ({1'b0, col_q} + 11'd1) >= clip_w_q;
  assign last       = col_end && (({1'b0, row_q} + 11'd1) >= clip_h_q);

  sbc_blend u_blend (
    .mode_i  (mode_q),
    .src_i   (geom_i.src),
    .dst_i   (geom_i.dst),
    .pixel_o (blend_pixel),
    .we_o    (blend_we)
  );

  // Next state
  always_comb begin
    active_d   = active_q;
    mode_d     = mode_q;
    clip_w_d   = clip_w_q;
    clip_h_d   = clip_h_q;
    col_d      = col_q;
    row_d      = row_q;
    src_base_d = src_base_q;
    dst_base_d = dst_base_q;
    stride_d   = stride_q;
    if (step_i) begin
      case (geom_i.kind)
        sbc_pkg::KindCommand: begin
          // a new command drops any running draw
          active_d = !empty;
          col_d    = '0;
          row_d    = '0;
          if (!empty) begin
            mode_d     = geom_i.mode;
            clip_w_d   = w2[10:0];
            clip_h_d   = h2[10:0];
            stride_d   = geom_i.sw;
            src_base_d = cmd_soff;
            dst_base_d = cmd_addr;
          end
        end
        sbc_pkg::KindPixel: begin
          if (active_q) begin
            if (last) begin
              active_d = 1'b0;
              col_d    = '0;
              row_d    = '0;
            end else if (col_end) begin
              col_d = '0;
              row_d = row_q + 1'b1;
            end else begin
              col_d = col_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result word
  always_comb begin
    res_d      = '0;
    res_d.kind = geom_i.kind;
    case (geom_i.kind)
      sbc_pkg::KindCommand: begin
        res_d.empty = empty;
        if (!empty) begin
          res_d.addr   = cmd_addr;
          res_d.soff   = cmd_soff;
          res_d.rect_w = w2[10:0];
          res_d.rect_h = h2[10:0];
        end
      end
      sbc_pkg::KindPixel: begin
        res_d.addr  = pix_addr;
        res_d.soff  = pix_soff;
        res_d.pixel = blend_pixel;
        res_d.we    = blend_we;
        res_d.last  = last;
      end
      default: ;
    endcase
  end

  // a pixel while idle is dropped without a result
  always_comb begin
    out_valid_d = out_valid_q;
    if (ld_i) begin
      out_valid_d = step_i && ((geom_i.kind == sbc_pkg::KindCommand) || active_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      mode_q      <= sbc_pkg::ModeKey;
      clip_w_q    <= '0;
      clip_h_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      src_base_q  <= '0;
      dst_base_q  <= '0;
      stride_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      mode_q      <= mode_d;
      clip_w_q    <= clip_w_d;
      clip_h_q    <= clip_h_d;
      col_q       <= col_d;
      row_q       <= row_d;
      src_base_q  <= src_base_d;
      dst_base_q  <= dst_base_d;
      stride_q    <= stride_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

/* hw/rtl/sprite_blit_clip_compose.sv */
// ----------------------------------------------------------------------------
// sprite_blit_clip_compose
// Sprite blitter: clips a draw command against the screen, then composes a
// raster-order pixel stream in one of four blend modes.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+---------------------------------
//  s_axis    | in  | s_axis_tvalid/tready    | tdata: command fields + pixels,
//            |     |                         | tuser: item kind
//  m_axis    | out | m_axis_tvalid/tready    | tdata: reply fields, tuser: kind,
//            |     |                         | tlast: final pixel of rectangle
//  cfg       | in  | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
//  One word accepted per clock while m_axis does not stall. A result is offered
//  once its word has passed, in order, the input register loaded by the
//  accepting edge, the percent/origin stage, the divide/row-product stage and
//  the clip-and-compose stage that loads the result register.
//  Reset clears all valid bits and draw state and loads the screen registers
//  with 640 x 480, pitch 2560.
//  Back-pressure on m_axis stalls only the stages that hold a word; empty
//  stages keep filling, so s_axis_tready stays high while a bubble remains.
//  A pixel word with no draw running leaves a bubble and gives no result.
//
module sprite_blit_clip_compose (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] sprite_index, [18:8] sprite_width, [29:19] sprite_height,
  // [45:30] center_x, [61:46] center_y, [77:62] draw_x, [93:78] draw_y,
  // [95:94] mode, [102:96] draw_percent, [134:103] source_pixel,
  // [166:135] dest_pixel, [167] zero
  input  logic [sbc_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] kind
  input  logic                          s_axis_tuser,

  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [25:0] dest_address, [45:26] source_offset, [56:46] rect_width,
  // [67:57] rect_height, [68] empty_rect, [100:69] out_pixel,
  // [101] write_enable, [103:102] zero
  output logic [sbc_pkg::OutDataW-1:0]  m_axis_tdata,
  // [0] reply_kind
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast,

  input  logic                          cfg_we_i,
  input  logic [sbc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sbc_pkg::CfgDataW-1:0]  cfg_data_i
);

  // Screen configuration registers
  logic [12:0] dest_width_q;
  logic [12:0] dest_height_q;
  logic [14:0] dest_pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_width_q  <= sbc_pkg::DestWidthRst;
      dest_height_q <= sbc_pkg::DestHeightRst;
      dest_pitch_q  <= sbc_pkg::DestPitchRst;
    end else if (cfg_we_i) begin
      case (sbc_pkg::cfg_reg_e'(cfg_idx_i))
        sbc_pkg::RegDestWidth:  dest_width_q  <= cfg_data_i[12:0];
        sbc_pkg::RegDestHeight: dest_height_q <= cfg_data_i[12:0];
        sbc_pkg::RegDestPitch:  dest_pitch_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow: each stage advances when its successor is empty or moving
  logic v1_q, v2_q, v3_q;
  logic out_valid;
  logic adv1, adv2, adv3, out_ld;

  assign out_ld        = !out_valid || m_axis_tready;
  assign adv3          = !v3_q || out_ld;
  assign adv2          = !v2_q || adv3;
  assign adv1          = !v1_q || adv2;
  assign s_axis_tready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Input register: unpack the word into named fields
  sbc_pkg::item_t item_d, item_q;

  always_comb begin
    item_d          = '0;
    item_d.kind     = sbc_pkg::item_kind_e'(s_axis_tuser);
    item_d.sprite_w = s_axis_tdata[18:8];
    item_d.sprite_h = s_axis_tdata[29:19];
    item_d.center_x = s_axis_tdata[45:30];
    item_d.center_y = s_axis_tdata[61:46];
    item_d.draw_x   = s_axis_tdata[77:62];
    item_d.draw_y   = s_axis_tdata[93:78];
    item_d.mode     = sbc_pkg::blend_mode_e'(s_axis_tdata[95:94]);
    item_d.pct      = s_axis_tdata[102:96];
    item_d.src      = s_axis_tdata[134:103];
    item_d.dst      = s_axis_tdata[166:135];
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      item_q <= item_d;
    end
  end

  // Command pre-processing (two stages)
  sbc_pkg::geom_t geom;

  sbc_prep u_prep (
    .clk_i        (clk_i),
    .item_i       (item_q),
    .ld2_i        (adv2),
    .ld3_i        (adv3),
    .dest_pitch_i (dest_pitch_q),
    .geom_o       (geom)
  );

  // Clip, draw state and result register
  sbc_pkg::result_t result;

  sbc_draw u_draw (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .geom_i        (geom),
    .step_i        (v3_q && out_ld),
    .ld_i          (out_ld),
    .dest_width_i  (dest_width_q),
    .dest_height_i (dest_height_q),
    .dest_pitch_i  (dest_pitch_q),
    .out_valid_o   (out_valid),
    .result_o      (result)
  );

  // Pack the result word
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = result.kind;
  assign m_axis_tlast  = result.last;
  assign m_axis_tdata  = {2'b00, result.we, result.pixel, result.empty, result.rect_h,
                          result.rect_w, result.soff, result.addr};

endmodule

/* hw/rtl/sbc_checker.sv */
// ----------------------------------------------------------------------------
// sbc_checker
// Port-level checks on the result stream of the sprite blitter.
// ----------------------------------------------------------------------------
module sbc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sbc_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);

  // Track whether a non-empty rectangle has been opened and not yet closed
  logic drawing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drawing_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (!m_axis_tuser) begin
        drawing_q <= !m_axis_tdata[68];
      end else if (m_axis_tlast) begin
        drawing_q <= 1'b0;
      end
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_reply_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[103:69] == '0 && !m_axis_tlast)
    else $error("command reply carries pixel fields");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser && m_axis_tdata[68] |-> m_axis_tdata[67:0] == '0)
    else $error("empty reply with non-zero geometry");

  a_pixel_in_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> drawing_q && m_axis_tdata[68:46] == '0)
    else $error("pixel result outside an open rectangle");

endmodule

bind sprite_blit_clip_compose sbc_checker u_sbc_checker (.*);
